// File: hdl/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, the S-box and the round primitives of the AES-128 cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [7:0]         byte_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Round constant for round r (1..10).
    function automatic byte_t rcon(input logic [3:0] r);
        byte_t v;
        case (r)
            4'd1:  v = 8'h01;
            4'd2:  v = 8'h02;
            4'd3:  v = 8'h04;
            4'd4:  v = 8'h08;
            4'd5:  v = 8'h10;
            4'd6:  v = 8'h20;
            4'd7:  v = 8'h40;
            4'd8:  v = 8'h80;
            4'd9:  v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Byte n of a block sits in bits 127-8n downto 120-8n.
    function automatic byte_t get_byte(input block_t b, input int unsigned n);
        return b[BLOCK_W-1-8*n -: 8];
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows.
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        byte_t  a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // One key schedule step: next round key from the previous one.
    function automatic block_t next_round_key(input block_t k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

// File: hdl/aes128_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered cipher round with its key schedule step alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_round
    import aes128_pkg::*;
#(
    parameter logic [3:0] ROUND = 4'd1,
    parameter bit         FINAL = 1'b0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire block_t in_state,
    input  wire block_t in_key,
    output logic        out_valid,
    output block_t      out_state,
    output block_t      out_key
);

    logic   valid_reg;
    block_t state_reg, state_next;
    block_t key_reg, key_next;

    // Round datapath: the new round key is added to the transformed state.
    always_comb
    begin
        key_next = next_round_key(in_key, ROUND);
        if (FINAL)
            state_next = sub_shift(in_state) ^ key_next;
        else
            state_next = mix_columns(sub_shift(in_state)) ^ key_next;
    end

    // Valid flag travels with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

`default_nettype wire

// File: hdl/aes128_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption core
// Fully unrolled, pipelined AES-128 encryption of one block per clock.
// ----------------------------------------------------------------------------
// The core takes a new block at every clock cycle in which start is high and
// busy is low; busy is always low, so one block per cycle is sustained. Each
// block passes through one stage for the initial key addition and one stage
// per round, with the round key expanded alongside the data in each stage.
// The ciphertext word appears for one cycle with done high and cannot be
// held off. Write the key through the configuration port only while no
// block is in flight.
`default_nettype none

module aes128_block_encrypt_core
    import aes128_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [HALF_W-1:0]    plain_high,
    input  wire logic [HALF_W-1:0]    plain_low,
    output logic                      done,
    output logic [HALF_W-1:0]         cipher_high,
    output logic [HALF_W-1:0]         cipher_low,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HALF_W-1:0]    cfg_data
);

    logic [HALF_W-1:0] key_high_reg, key_low_reg;
    logic              v0_reg;
    block_t            s0_reg, k0_reg;

    logic   v   [NUM_ROUNDS+1];
    block_t st  [NUM_ROUNDS+1];
    block_t key [NUM_ROUNDS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry stage: initial AddRoundKey.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= {plain_high, plain_low} ^ {key_high_reg, key_low_reg};
        k0_reg <= {key_high_reg, key_low_reg};
    end

    assign v[0]   = v0_reg;
    assign st[0]  = s0_reg;
    assign key[0] = k0_reg;

    // Round stages.
    for (genvar r = 1; r <= NUM_ROUNDS; r++)
    begin : g_round
        aes128_round #(
            .ROUND (4'(r)),
            .FINAL (r == NUM_ROUNDS)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[r-1]),
            .in_state  (st[r-1]),
            .in_key    (key[r-1]),
            .out_valid (v[r]),
            .out_state (st[r]),
            .out_key   (key[r])
        );
    end

    assign done        = v[NUM_ROUNDS];
    assign cipher_high = st[NUM_ROUNDS][BLOCK_W-1:HALF_W];
    assign cipher_low  = st[NUM_ROUNDS][HALF_W-1:0];

endmodule

`default_nettype wire

// File: hdl/aes128_checker.sv
// ----------------------------------------------------------------------------
// AES-128 port checker
// Checks the latency and handshake behavior seen at the core's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_checker
    import aes128_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic cfg_ready
);

    localparam int unsigned LATENCY = NUM_ROUNDS + 1;

    // A word accepted now raises done once it has passed the entry stage and every round stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not complete on time");

    // No word leaves unless a word was accepted to match it at the entry stage.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without accepted word");

    // Nothing leaves during or right after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result right after reset");

    // The core never refuses a word or a key write.
    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("core stalled");

endmodule

bind aes128_block_encrypt_core aes128_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
